### rtl/core/sbbl_pkg.sv
// Shared types and constants for the sample bin builder and locator.
// Used by the controller, the datapath and the top level; depends on nothing.
package sbbl_pkg;

  localparam int DEF_MAX_SAMPLES = 64;
  localparam int DEF_VALUE_BITS  = 32;

  localparam int IN_VALUE_W = 32;
  localparam int STATUS_W   = 3;
  localparam int BIN_W      = 7;
  localparam int MBS_W      = 31;
  localparam int CFG_IDX_W  = 1;

  localparam logic [CFG_IDX_W-1:0] REG_STRICT_MODE  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_BIN_SIZE = 1'd1;

  localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] ST_TOO_FEW   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_TOO_CLOSE = 3'd2;
  localparam logic [STATUS_W-1:0] ST_TOO_MANY  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_BELOW     = 3'd4;
  localparam logic [STATUS_W-1:0] ST_ABOVE     = 3'd5;
  localparam logic [STATUS_W-1:0] ST_NO_TABLE  = 3'd6;

  typedef enum logic [4:0] {
    S_IDLE, S_DISP, S_INS_RD, S_INS_CMP, S_INS_WR,
    S_B_CHK0, S_B_CHK1, S_B_CHK2, S_B_FIRST, S_B_MID, S_B_LASTS, S_B_MAX,
    S_B_FIX, S_B_FAIL, S_F_RD, S_F_CMP, S_F_END, S_RESULT
  } state_t;

  typedef enum logic [4:0] {
    OP_NOP, OP_CAPTURE, OP_DISP, OP_INS_RD, OP_INS_SHIFT, OP_INS_WR,
    OP_B_CHK0, OP_B_CHK1, OP_B_CHK2, OP_B_FIRST, OP_B_MID, OP_B_LASTS, OP_B_MAX,
    OP_B_FIX, OP_B_FAIL, OP_F_RD, OP_F_CMP, OP_F_END, OP_RESULT
  } op_t;

  typedef struct packed {
    logic find;
    logic last;
    logic full;
    logic no_table;
    logic ovf;
    logic few;
    logic close;
    logic i_zero;
    logic gt;
    logic mid_more;
    logic strict;
    logic search_on;
    logic out_free;
  } stat_t;

endpackage

### rtl/core/sbbl_ctrl.sv
// Sequencing state machine for the sample bin builder and locator.
// Depends on sbbl_pkg; drives datapath commands from datapath status.
module sbbl_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  sbbl_pkg::stat_t stat,
  output sbbl_pkg::op_t  op
);

  sbbl_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sbbl_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    op        = sbbl_pkg::OP_NOP;
    in_stall  = (state_r != sbbl_pkg::S_IDLE);
    unique case (state_r)
      sbbl_pkg::S_IDLE: begin
        if (in_valid) begin
          op        = sbbl_pkg::OP_CAPTURE;
          state_nxt = sbbl_pkg::S_DISP;
        end
      end
      sbbl_pkg::S_DISP: begin
        op = sbbl_pkg::OP_DISP;
        if (stat.find) begin
          state_nxt = stat.no_table ? sbbl_pkg::S_RESULT : sbbl_pkg::S_F_RD;
        end else if (stat.full) begin
          state_nxt = stat.last ? sbbl_pkg::S_B_CHK0 : sbbl_pkg::S_IDLE;
        end else begin
          state_nxt = sbbl_pkg::S_INS_RD;
        end
      end
      sbbl_pkg::S_INS_RD: begin
        op        = sbbl_pkg::OP_INS_RD;
        state_nxt = stat.i_zero ? sbbl_pkg::S_INS_WR : sbbl_pkg::S_INS_CMP;
      end
      sbbl_pkg::S_INS_CMP: begin
        if (stat.gt) begin
          op        = sbbl_pkg::OP_INS_SHIFT;
          state_nxt = sbbl_pkg::S_INS_RD;
        end else begin
          state_nxt = sbbl_pkg::S_INS_WR;
        end
      end
      sbbl_pkg::S_INS_WR: begin
        op        = sbbl_pkg::OP_INS_WR;
        state_nxt = stat.last ? sbbl_pkg::S_B_CHK0 : sbbl_pkg::S_IDLE;
      end
      sbbl_pkg::S_B_CHK0: begin
        op        = sbbl_pkg::OP_B_CHK0;
        state_nxt = (stat.ovf || stat.few) ? sbbl_pkg::S_B_FAIL : sbbl_pkg::S_B_CHK1;
      end
      sbbl_pkg::S_B_CHK1: begin
        op        = sbbl_pkg::OP_B_CHK1;
        state_nxt = sbbl_pkg::S_B_CHK2;
      end
      sbbl_pkg::S_B_CHK2: begin
        op        = sbbl_pkg::OP_B_CHK2;
        state_nxt = stat.close ? sbbl_pkg::S_B_FAIL : sbbl_pkg::S_B_FIRST;
      end
      sbbl_pkg::S_B_FIRST: begin
        op        = sbbl_pkg::OP_B_FIRST;
        state_nxt = sbbl_pkg::S_B_MID;
      end
      sbbl_pkg::S_B_MID: begin
        op        = sbbl_pkg::OP_B_MID;
        state_nxt = stat.mid_more ? sbbl_pkg::S_B_MID : sbbl_pkg::S_B_LASTS;
      end
      sbbl_pkg::S_B_LASTS: begin
        op        = sbbl_pkg::OP_B_LASTS;
        state_nxt = stat.strict ? sbbl_pkg::S_B_FIX : sbbl_pkg::S_B_MAX;
      end
      sbbl_pkg::S_B_MAX: begin
        op        = sbbl_pkg::OP_B_MAX;
        state_nxt = sbbl_pkg::S_B_FIX;
      end
      sbbl_pkg::S_B_FIX: begin
        op        = sbbl_pkg::OP_B_FIX;
        state_nxt = sbbl_pkg::S_RESULT;
      end
      sbbl_pkg::S_B_FAIL: begin
        op        = sbbl_pkg::OP_B_FAIL;
        state_nxt = sbbl_pkg::S_RESULT;
      end
      sbbl_pkg::S_F_RD: begin
        op        = sbbl_pkg::OP_F_RD;
        state_nxt = stat.search_on ? sbbl_pkg::S_F_CMP : sbbl_pkg::S_F_END;
      end
      sbbl_pkg::S_F_CMP: begin
        op        = sbbl_pkg::OP_F_CMP;
        state_nxt = sbbl_pkg::S_F_RD;
      end
      sbbl_pkg::S_F_END: begin
        op        = sbbl_pkg::OP_F_END;
        state_nxt = sbbl_pkg::S_RESULT;
      end
      sbbl_pkg::S_RESULT: begin
        if (stat.out_free) begin
          op        = sbbl_pkg::OP_RESULT;
          state_nxt = sbbl_pkg::S_IDLE;
        end
      end
      default: state_nxt = sbbl_pkg::S_IDLE;
    endcase
  end

endmodule

### rtl/core/sbbl_dp.sv
// Datapath: sample store, edge table, counters, search registers and result register.
// Depends on sbbl_pkg; carries out one command from the controller per cycle.
module sbbl_dp #(
  parameter int MAX_SAMPLES = sbbl_pkg::DEF_MAX_SAMPLES,
  parameter int VALUE_BITS  = sbbl_pkg::DEF_VALUE_BITS
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  sbbl_pkg::op_t                      op,
  output sbbl_pkg::stat_t                    stat,
  input  logic                               in_action,
  input  logic signed [sbbl_pkg::IN_VALUE_W-1:0] in_value,
  input  logic                               in_last,
  input  logic                               cfg_we,
  input  logic [sbbl_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [sbbl_pkg::MBS_W-1:0]         cfg_wdata,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [sbbl_pkg::STATUS_W-1:0]      out_status,
  output logic [sbbl_pkg::BIN_W-1:0]         out_bin_index,
  output logic [sbbl_pkg::BIN_W-1:0]         out_bin_count
);

  localparam int VB    = VALUE_BITS;
  localparam int MS    = MAX_SAMPLES;
  localparam int ED    = MAX_SAMPLES + 3;
  localparam int CW    = $clog2(MS + 1);
  localparam int IW    = $clog2(MS + 4);
  localparam int SAW   = $clog2(MS);
  localparam int EAW   = $clog2(ED);
  localparam int DW    = VB + 32;
  localparam int SXW   = sbbl_pkg::IN_VALUE_W + 64;

  logic [VB-1:0] smem [MS];
  logic [VB-1:0] emem [ED];

  logic [VB-1:0] key_r, key_nxt, srd_r, edr_r;
  logic [VB-1:0] first_r, first_nxt, prev_r, prev_nxt, lastv_r, lastv_nxt;
  logic [VB-1:0] back_r, back_nxt;
  logic          act_r, act_nxt, last_r, last_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          ovf_r, ovf_nxt, tv_r, tv_nxt, eql_r, eql_nxt;
  logic [IW-1:0] ecnt_r, ecnt_nxt, i_r, i_nxt, k_r, k_nxt;
  logic [IW-1:0] lo_r, lo_nxt, hi_r, hi_nxt, mid_r, mid_nxt, bin_r, bin_nxt;
  logic [sbbl_pkg::STATUS_W-1:0] st_r, st_nxt;
  logic          strict_r;
  logic [sbbl_pkg::MBS_W-1:0] mbs_r, mbs_eff;
  logic          out_valid_r, out_valid_nxt;
  logic [sbbl_pkg::STATUS_W-1:0] out_status_r, out_status_nxt;
  logic [sbbl_pkg::BIN_W-1:0] out_bin_r, out_bin_nxt, out_cnt_r, out_cnt_nxt;

  logic          s_we, e_we;
  logic [SAW-1:0] s_wa, s_ra;
  logic [EAW-1:0] e_wa, e_ra;
  logic [VB-1:0] s_wd, e_wd;
  logic          emit_en, emit_ok;
  logic [VB-1:0] emit_val, last_cand, mid_val;
  logic [SXW-1:0] sx;
  logic [VB-1:0] in_key;
  logic [IW-1:0] cnt_w, mid_calc, i_inc, idx_tmp;
  logic [31:0]   bins_w, bin_w;
  logic          close;

  assign sx      = {{64{in_value[sbbl_pkg::IN_VALUE_W-1]}}, in_value};
  assign in_key  = {~sx[VB-1], sx[VB-2:0]};
  assign mbs_eff = (mbs_r == '0) ? sbbl_pkg::MBS_W'(1) : mbs_r;
  assign cnt_w   = IW'(cnt_r);
  assign i_inc   = i_r + IW'(1);
  assign mid_calc = lo_r + ((hi_r - lo_r) >> 1);
  assign mid_val = (prev_r >> 1) + (srd_r >> 1) + VB'(prev_r[0] & srd_r[0]);
  assign last_cand = strict_r ? lastv_r : {VB{1'b1}};
  assign close   = DW'(srd_r - first_r) < DW'(mbs_eff);
  assign emit_ok = (k_r == '0) ||
                   ((emit_val > back_r) && (DW'(emit_val - back_r) > DW'(mbs_eff)));

  always_comb begin
    stat.find      = act_r;
    stat.last      = last_r;
    stat.full      = (cnt_r == CW'(MS));
    stat.no_table  = !tv_r || (ecnt_r < IW'(2));
    stat.ovf       = ovf_r;
    stat.few       = (cnt_r < CW'(2));
    stat.close     = close;
    stat.i_zero    = (i_r == '0);
    stat.gt        = (srd_r > key_r);
    stat.mid_more  = (i_inc < cnt_w);
    stat.strict    = strict_r;
    stat.search_on = (lo_r < hi_r);
    stat.out_free  = !out_valid_r || !out_stall;
  end

  always_comb begin
    key_nxt = key_r;     act_nxt = act_r;     last_nxt = last_r;
    cnt_nxt = cnt_r;     ovf_nxt = ovf_r;     tv_nxt = tv_r;
    ecnt_nxt = ecnt_r;   i_nxt = i_r;         k_nxt = k_r;
    lo_nxt = lo_r;       hi_nxt = hi_r;       mid_nxt = mid_r;
    bin_nxt = bin_r;     st_nxt = st_r;       eql_nxt = eql_r;
    first_nxt = first_r; prev_nxt = prev_r;   lastv_nxt = lastv_r;
    back_nxt = back_r;
    out_status_nxt = out_status_r;
    out_bin_nxt = out_bin_r;
    out_cnt_nxt = out_cnt_r;
    out_valid_nxt = out_valid_r && out_stall;
    s_we = 1'b0; s_wa = i_r[SAW-1:0]; s_wd = key_r; s_ra = '0;
    e_we = 1'b0; e_wa = k_r[EAW-1:0]; e_wd = last_cand; e_ra = mid_calc[EAW-1:0];
    emit_en = 1'b0; emit_val = first_r;
    idx_tmp = '0;
    bins_w = '0; bin_w = '0;
    unique case (op)
      sbbl_pkg::OP_NOP: ;
      sbbl_pkg::OP_CAPTURE: begin
        key_nxt  = in_key;
        act_nxt  = in_action;
        last_nxt = in_last;
        i_nxt    = cnt_w;
        if (!in_action && (cnt_r == CW'(MS))) ovf_nxt = 1'b1;
      end
      sbbl_pkg::OP_DISP: begin
        st_nxt  = sbbl_pkg::ST_NO_TABLE;
        bin_nxt = '0;
        lo_nxt  = '0;
        hi_nxt  = ecnt_r;
        eql_nxt = 1'b0;
      end
      sbbl_pkg::OP_INS_RD: begin
        idx_tmp = i_r - IW'(1);
        s_ra    = idx_tmp[SAW-1:0];
      end
      sbbl_pkg::OP_INS_SHIFT: begin
        s_we  = 1'b1;
        s_wd  = srd_r;
        i_nxt = i_r - IW'(1);
      end
      sbbl_pkg::OP_INS_WR: begin
        s_we    = 1'b1;
        cnt_nxt = cnt_r + CW'(1);
      end
      sbbl_pkg::OP_B_CHK0: begin
        st_nxt = ovf_r ? sbbl_pkg::ST_TOO_MANY :
                 (cnt_r < CW'(2)) ? sbbl_pkg::ST_TOO_FEW : sbbl_pkg::ST_OK;
        s_ra = '0;
      end
      sbbl_pkg::OP_B_CHK1: begin
        first_nxt = srd_r;
        k_nxt     = '0;
        idx_tmp   = cnt_w - IW'(1);
        s_ra      = idx_tmp[SAW-1:0];
      end
      sbbl_pkg::OP_B_CHK2: begin
        lastv_nxt = srd_r;
        k_nxt     = '0;
        if (close) begin
          st_nxt = sbbl_pkg::ST_TOO_CLOSE;
        end else if (!strict_r) begin
          emit_en  = 1'b1;
          emit_val = '0;
        end
      end
      sbbl_pkg::OP_B_FIRST: begin
        emit_en  = 1'b1;
        emit_val = first_r;
        prev_nxt = first_r;
        i_nxt    = IW'(1);
        s_ra     = SAW'(1);
      end
      sbbl_pkg::OP_B_MID: begin
        emit_en  = 1'b1;
        emit_val = mid_val;
        prev_nxt = srd_r;
        i_nxt    = i_inc;
        s_ra     = i_inc[SAW-1:0];
      end
      sbbl_pkg::OP_B_LASTS: begin
        emit_en  = 1'b1;
        emit_val = lastv_r;
      end
      sbbl_pkg::OP_B_MAX: begin
        emit_en  = 1'b1;
        emit_val = {VB{1'b1}};
      end
      sbbl_pkg::OP_B_FIX: begin
        ecnt_nxt = k_r;
        e_wd     = last_cand;
        if (back_r != last_cand) begin
          e_we = 1'b1;
          if (k_r == IW'(1)) begin
            e_wa     = k_r[EAW-1:0];
            ecnt_nxt = IW'(2);
          end else begin
            idx_tmp = k_r - IW'(1);
            e_wa    = idx_tmp[EAW-1:0];
          end
        end
        tv_nxt  = 1'b1;
        cnt_nxt = '0;
        ovf_nxt = 1'b0;
        bin_nxt = '0;
      end
      sbbl_pkg::OP_B_FAIL: begin
        tv_nxt   = 1'b0;
        ecnt_nxt = '0;
        cnt_nxt  = '0;
        ovf_nxt  = 1'b0;
        bin_nxt  = '0;
      end
      sbbl_pkg::OP_F_RD: begin
        mid_nxt = mid_calc;
      end
      sbbl_pkg::OP_F_CMP: begin
        if (edr_r > key_r) hi_nxt = mid_r;
        else lo_nxt = mid_r + IW'(1);
        if (mid_r == ecnt_r - IW'(1)) eql_nxt = (edr_r == key_r);
      end
      sbbl_pkg::OP_F_END: begin
        bin_nxt = '0;
        if (lo_r == '0) begin
          st_nxt = sbbl_pkg::ST_BELOW;
        end else if (lo_r < ecnt_r) begin
          st_nxt  = sbbl_pkg::ST_OK;
          bin_nxt = lo_r - IW'(1);
        end else if (!eql_r) begin
          st_nxt = sbbl_pkg::ST_ABOVE;
        end else begin
          st_nxt  = sbbl_pkg::ST_OK;
          bin_nxt = ecnt_r - IW'(2);
        end
      end
      sbbl_pkg::OP_RESULT: begin
        bins_w = (tv_r && (ecnt_r >= IW'(2))) ? 32'(ecnt_r - IW'(1)) : 32'd0;
        bin_w  = (st_r == sbbl_pkg::ST_OK) ? 32'(bin_r) : 32'd0;
        out_status_nxt = st_r;
        out_bin_nxt    = bin_w[sbbl_pkg::BIN_W-1:0];
        out_cnt_nxt    = bins_w[sbbl_pkg::BIN_W-1:0];
        out_valid_nxt  = 1'b1;
      end
      default: ;
    endcase
    // A candidate edge is kept when it clears the previous kept edge by more
    // than the minimum bin size; the first candidate is always kept.
    if (emit_en && emit_ok) begin
      e_we     = 1'b1;
      e_wa     = k_r[EAW-1:0];
      e_wd     = emit_val;
      back_nxt = emit_val;
      k_nxt    = k_r + IW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (s_we) smem[s_wa] <= s_wd;
    srd_r <= smem[s_ra];
    if (e_we) emem[e_wa] <= e_wd;
    edr_r <= emem[e_ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      ovf_r       <= 1'b0;
      tv_r        <= 1'b0;
      ecnt_r      <= '0;
      strict_r    <= 1'b1;
      mbs_r       <= sbbl_pkg::MBS_W'(1);
      out_valid_r <= 1'b0;
    end else begin
      cnt_r       <= cnt_nxt;
      ovf_r       <= ovf_nxt;
      tv_r        <= tv_nxt;
      ecnt_r      <= ecnt_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          sbbl_pkg::REG_STRICT_MODE:  strict_r <= cfg_wdata[0];
          sbbl_pkg::REG_MIN_BIN_SIZE: mbs_r    <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;     act_r <= act_nxt;     last_r <= last_nxt;
    i_r <= i_nxt;         k_r <= k_nxt;         lo_r <= lo_nxt;
    hi_r <= hi_nxt;       mid_r <= mid_nxt;     bin_r <= bin_nxt;
    st_r <= st_nxt;       eql_r <= eql_nxt;     first_r <= first_nxt;
    prev_r <= prev_nxt;   lastv_r <= lastv_nxt; back_r <= back_nxt;
    out_status_r <= out_status_nxt;
    out_bin_r    <= out_bin_nxt;
    out_cnt_r    <= out_cnt_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_bin_index = out_bin_r;
  assign out_bin_count = out_cnt_r;

endmodule

### rtl/core/sample_bin_builder_and_locator.sv
// Sample bin builder and locator. Loads insert a signed value into a sorted
// store by shifting larger entries up one at a time. A load marked last then
// builds the bin edges from the stored samples, one candidate edge per cycle.
// A find runs a binary search over the edge table. The sample store and the
// edge table each have a single registered read port; one item is in work at
// a time, and the result register lets the next item in while a result still
// waits. Top level: joins the controller and the datapath.
module sample_bin_builder_and_locator #(
  parameter int MAX_SAMPLES = sbbl_pkg::DEF_MAX_SAMPLES,
  parameter int VALUE_BITS  = sbbl_pkg::DEF_VALUE_BITS
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic                                   in_action,
  input  logic signed [sbbl_pkg::IN_VALUE_W-1:0] in_value,
  input  logic                                   in_last,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic [sbbl_pkg::STATUS_W-1:0]          out_status,
  output logic [sbbl_pkg::BIN_W-1:0]             out_bin_index,
  output logic [sbbl_pkg::BIN_W-1:0]             out_bin_count,
  input  logic                                   cfg_we,
  input  logic [sbbl_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [sbbl_pkg::MBS_W-1:0]             cfg_wdata
);

  sbbl_pkg::op_t   op;
  sbbl_pkg::stat_t stat;

  sbbl_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .op       (op)
  );

  sbbl_dp #(
    .MAX_SAMPLES (MAX_SAMPLES),
    .VALUE_BITS  (VALUE_BITS)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .op            (op),
    .stat          (stat),
    .in_action     (in_action),
    .in_value      (in_value),
    .in_last       (in_last),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_status    (out_status),
    .out_bin_index (out_bin_index),
    .out_bin_count (out_bin_count)
  );

endmodule

### sim/sample_bin_builder_and_locator_tb.sv
// Self-checking testbench for sample_bin_builder_and_locator.
// Holds its own model of the sorted store, the edge build and the bin search,
// and checks every result; depends on sbbl_pkg and the RTL alone.
`timescale 1ns / 100ps

module sample_bin_builder_and_locator_tb;

  localparam int NSAMP       = 64;
  localparam int NEDGE       = NSAMP + 3;
  localparam int SETTLE      = 160;
  localparam int CYCLE_LIMIT = 1000000;

  typedef struct {
    logic [sbbl_pkg::STATUS_W-1:0] status;
    logic [sbbl_pkg::BIN_W-1:0]    bin_index;
    logic [sbbl_pkg::BIN_W-1:0]    bin_count;
  } bin_res_t;

  typedef struct {
    bit                            find;
    logic [31:0]                   value;
    bit                            lst;
    bit                            fixed;
    logic [sbbl_pkg::STATUS_W-1:0] status;
    logic [sbbl_pkg::BIN_W-1:0]    bin_index;
    logic [sbbl_pkg::BIN_W-1:0]    bin_count;
  } stim_row_t;

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            in_valid = 1'b0;
  logic                            in_stall;
  logic                            in_action = 1'b0;
  logic signed [31:0]              in_value = '0;
  logic                            in_last = 1'b0;
  logic                            out_valid;
  logic                            out_stall = 1'b0;
  logic [sbbl_pkg::STATUS_W-1:0]   out_status;
  logic [sbbl_pkg::BIN_W-1:0]      out_bin_index;
  logic [sbbl_pkg::BIN_W-1:0]      out_bin_count;
  logic                            cfg_we = 1'b0;
  logic [sbbl_pkg::CFG_IDX_W-1:0]  cfg_index = sbbl_pkg::REG_STRICT_MODE;
  logic [sbbl_pkg::MBS_W-1:0]      cfg_wdata = '0;

  sample_bin_builder_and_locator dut (.*);

  always #6 clk = ~clk;

  // Model state, kept as order-preserving keys (sign bit flipped).
  bit [31:0]   sorted_keys[NSAMP];
  int unsigned key_count;
  bit          store_overflow;
  bit [31:0]   edge_keys[NEDGE];
  int unsigned edge_total;
  bit          table_ok;
  bit          strict_q = 1'b1;
  bit [30:0]   min_size_q = 31'd1;

  bin_res_t    pending_bins[$];
  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;
  logic [31:0] value_base = '0;
  logic [31:0] value_spread = 32'd255;
  int unsigned burst_left = 0;

  function automatic bit [31:0] floor_mid(bit [31:0] a, bit [31:0] b);
    return (a >> 1) + (b >> 1) + {31'd0, a[0] & b[0]};
  endfunction

  function automatic logic [sbbl_pkg::STATUS_W-1:0] build_edges();
    bit [31:0]   cand[NEDGE + 1];
    int unsigned nc, k;
    bit [31:0]   step, back;
    nc = 0;
    k = 0;
    step = (min_size_q == 0) ? 32'd1 : {1'b0, min_size_q};
    if (store_overflow) return sbbl_pkg::ST_TOO_MANY;
    if (key_count < 2) return sbbl_pkg::ST_TOO_FEW;
    if (sorted_keys[key_count-1] - sorted_keys[0] < step) return sbbl_pkg::ST_TOO_CLOSE;
    if (!strict_q) cand[nc++] = 32'h0000_0000;
    cand[nc++] = sorted_keys[0];
    for (int i = 1; i < key_count; i++)
      cand[nc++] = floor_mid(sorted_keys[i-1], sorted_keys[i]);
    cand[nc++] = sorted_keys[key_count-1];
    if (!strict_q) cand[nc++] = 32'hFFFF_FFFF;
    edge_keys[k++] = cand[0];
    for (int i = 1; i < nc; i++) begin
      back = edge_keys[k-1];
      if (cand[i] > back && cand[i] - back > step) edge_keys[k++] = cand[i];
    end
    // The top edge always ends on the last candidate; a lone first edge gets
    // it appended so that the table still holds one bin.
    if (edge_keys[k-1] != cand[nc-1]) begin
      if (k == 1) edge_keys[k++] = cand[nc-1];
      else edge_keys[k-1] = cand[nc-1];
    end
    edge_total = k;
    table_ok = 1'b1;
    return sbbl_pkg::ST_OK;
  endfunction

  function automatic bit locate_or_build(bit find, logic [31:0] value, bit lst,
                                         output bin_res_t res);
    bit [31:0]   key;
    int unsigned pos, lo, hi, mid, bin;
    logic [sbbl_pkg::STATUS_W-1:0] st;
    key = value ^ 32'h8000_0000;
    st = sbbl_pkg::ST_OK;
    bin = 0;
    if (!find) begin
      if (key_count < NSAMP) begin
        pos = key_count;
        while (pos > 0 && sorted_keys[pos-1] > key) begin
          sorted_keys[pos] = sorted_keys[pos-1];
          pos--;
        end
        sorted_keys[pos] = key;
        key_count++;
      end else begin
        store_overflow = 1'b1;
      end
      if (!lst) return 1'b0;
      st = build_edges();
      if (st != sbbl_pkg::ST_OK) begin
        table_ok = 1'b0;
        edge_total = 0;
      end
      key_count = 0;
      store_overflow = 1'b0;
    end else if (!table_ok || edge_total < 2) begin
      st = sbbl_pkg::ST_NO_TABLE;
    end else begin
      lo = 0;
      hi = edge_total;
      while (lo < hi) begin
        mid = lo + (hi - lo) / 2;
        if (edge_keys[mid] > key) hi = mid;
        else lo = mid + 1;
      end
      if (key < edge_keys[0]) st = sbbl_pkg::ST_BELOW;
      else if (lo < edge_total) bin = lo - 1;
      else if (key > edge_keys[edge_total-1]) st = sbbl_pkg::ST_ABOVE;
      else bin = edge_total - 2;
    end
    res.status    = st;
    res.bin_index = (st == sbbl_pkg::ST_OK) ? bin[sbbl_pkg::BIN_W-1:0] : '0;
    res.bin_count = (table_ok && edge_total >= 2) ?
                    sbbl_pkg::BIN_W'(edge_total - 1) : '0;
    return 1'b1;
  endfunction

  // Drives one item and waits for it to be taken; fixed rows override the
  // model's expectation but still advance its state.
  task automatic send_item(stim_row_t row);
    bin_res_t res;
    @(negedge clk);
    in_valid  = 1'b1;
    in_action = row.find;
    in_value  = row.value;
    in_last   = row.lst;
    do @(posedge clk); while (in_stall);
    if (locate_or_build(row.find, row.value, row.lst, res)) begin
      if (row.fixed) begin
        res.status    = row.status;
        res.bin_index = row.bin_index;
        res.bin_count = row.bin_count;
      end
      pending_bins.insert(pending_bins.size(), res);
    end
  endtask

  task automatic pace();
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        @(negedge clk);
        in_valid = 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
  endtask

  task automatic send_plain(bit find, logic [31:0] value, bit lst);
    stim_row_t row;
    row = '{find, value, lst, 1'b0, sbbl_pkg::ST_OK, '0, '0};
    pace();
    send_item(row);
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    wait (pending_bins.size() == 0);
    // A load without last can still be shifting the store.
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_cfg(bit strict, logic [sbbl_pkg::MBS_W-1:0] min_size);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = sbbl_pkg::REG_STRICT_MODE;
    cfg_wdata = {30'd0, strict};
    @(negedge clk);
    cfg_index = sbbl_pkg::REG_MIN_BIN_SIZE;
    cfg_wdata = min_size;
    @(negedge clk);
    cfg_we = 1'b0;
    strict_q   = strict;
    min_size_q = min_size;
  endtask

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return $urandom();
      1:       return 32'h8000_0000;
      2:       return 32'h7FFF_FFFF;
      default: return value_base + $urandom_range(0, value_spread);
    endcase
  endfunction

  task automatic load_set(int unsigned n);
    for (int i = 0; i < n; i++) send_plain(1'b0, pick_value(), i == n - 1);
  endtask

  stim_row_t directed_rows[] = '{
    '{1, 32'h0000_0000, 0, 1, sbbl_pkg::ST_NO_TABLE,  0, 0},
    '{0, 32'h0000_0005, 1, 1, sbbl_pkg::ST_TOO_FEW,   0, 0},
    '{0, 32'h0000_0000, 0, 0, sbbl_pkg::ST_OK,        0, 0},
    '{0, 32'h0000_0000, 1, 1, sbbl_pkg::ST_TOO_CLOSE, 0, 0},
    '{0, 32'h0000_0014, 0, 0, sbbl_pkg::ST_OK,        0, 0},
    '{0, 32'h0000_000A, 1, 0, sbbl_pkg::ST_OK,        0, 0},
    '{1, 32'h0000_0005, 0, 1, sbbl_pkg::ST_BELOW,     0, 2},
    '{1, 32'h0000_0019, 0, 1, sbbl_pkg::ST_ABOVE,     0, 2},
    '{1, 32'h0000_000A, 0, 0, sbbl_pkg::ST_OK,        0, 0},
    '{1, 32'h0000_000E, 0, 0, sbbl_pkg::ST_OK,        0, 0},
    '{1, 32'h0000_000F, 0, 0, sbbl_pkg::ST_OK,        0, 0},
    '{1, 32'h0000_0014, 0, 0, sbbl_pkg::ST_OK,        0, 0},
    '{0, 32'h7FFF_FFFF, 0, 0, sbbl_pkg::ST_OK,        0, 0},
    '{0, 32'h8000_0000, 1, 0, sbbl_pkg::ST_OK,        0, 0},
    '{1, 32'h8000_0000, 0, 0, sbbl_pkg::ST_OK,        0, 0},
    '{1, 32'h7FFF_FFFF, 0, 0, sbbl_pkg::ST_OK,        0, 0},
    '{1, 32'hFFFF_FFFF, 0, 0, sbbl_pkg::ST_OK,        0, 0},
    '{1, 32'h0000_0000, 0, 0, sbbl_pkg::ST_OK,        0, 0}
  };

  // Receiver stall pattern: switches between no stall, random and long runs.
  int unsigned stall_mode = 0;
  always @(negedge clk) begin
    if (cycle_count % 97 == 0) stall_mode = $urandom_range(0, 2);
    case (stall_mode)
      0:       out_stall <= 1'b0;
      1:       out_stall <= ($urandom_range(0, 2) == 0);
      default: out_stall <= (cycle_count % 16) < 10;
    endcase
  end

  always @(posedge clk) begin
    bin_res_t want;
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else if (rst_n && out_valid && !out_stall) begin
      if (pending_bins.size() == 0) begin
        $display("%0t: unexpected result status=%0d bin=%0d count=%0d", $realtime,
                 out_status, out_bin_index, out_bin_count);
        mismatch_count++;
      end else begin
        want = pending_bins.pop_front();
        if (out_status !== want.status) begin
          $display("%0t: status expected %0d got %0d", $realtime, want.status, out_status);
          mismatch_count++;
        end
        if (out_bin_index !== want.bin_index) begin
          $display("%0t: bin_index expected %0d got %0d", $realtime, want.bin_index,
                   out_bin_index);
          mismatch_count++;
        end
        if (out_bin_count !== want.bin_count) begin
          $display("%0t: bin_count expected %0d got %0d", $realtime, want.bin_count,
                   out_bin_count);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    int unsigned sets;
    repeat (5) @(negedge clk);
    rst_n = 1'b1;

    foreach (directed_rows[i]) send_item(directed_rows[i]);
    drain();

    // A bin size equal to the whole span keeps only the first candidate edge; the top edge is then appended.
    write_cfg(1'b1, 31'd100);
    send_plain(1'b0, 32'd0, 1'b0);
    send_plain(1'b0, 32'd100, 1'b1);
    send_plain(1'b1, 32'd100, 1'b0);
    send_plain(1'b1, 32'd50, 1'b0);
    drain();

    for (int phase = 0; phase < 10; phase++) begin
      case (phase)
        0: write_cfg(1'b1, 31'd1);
        1: write_cfg(1'b0, 31'd1);
        2: write_cfg(1'b1, 31'h7FFF_FFFF);
        3: write_cfg(1'b0, 31'h7FFF_FFFF);
        4: write_cfg(1'b1, 31'd0);
        5: write_cfg(1'b0, 31'd0);
        default: write_cfg(1'($urandom_range(0, 1)),
                           sbbl_pkg::MBS_W'($urandom_range(1, 1 << ($urandom % 31))));
      endcase
      sets = 5;
      for (int s = 0; s < sets; s++) begin
        value_base = $urandom();
        case ($urandom_range(0, 3))
          0: value_spread = 32'd15;
          1: value_spread = 32'h0001_0000;
          2: value_spread = 32'h0100_0000;
          default: value_spread = 32'hFFFF_FFFF;
        endcase
        case ($urandom_range(0, 19))
          0:       load_set(1);
          1:       load_set(NSAMP);
          2:       load_set(NSAMP + 2);
          default: load_set($urandom_range(2, 8));
        endcase
        repeat ($urandom_range(1, 6)) send_plain(1'b1, pick_value(), 1'b0);
        // Noise: stray items of either kind with random fields.
        if ($urandom_range(0, 3) == 0)
          send_plain($urandom_range(0, 1), $urandom(), $urandom_range(0, 1));
      end
      drain();
    end

    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
